// File: hdl/lqrbw_pkg.sv
// Shared types and constants of the wheel-leg balance controller.
// Holds the item structs, event and register codes, fixed-point constants.
// No dependencies.
`default_nettype none

package lqrbw_pkg;

    localparam int unsigned DATA_W    = 32;
    localparam int unsigned CFG_W     = 31;
    localparam int unsigned CFG_COUNT = 8;
    localparam int unsigned CFG_IDX_W = 3;

    localparam int unsigned MUL_A_W = 33;
    localparam int unsigned MUL_B_W = 32;
    localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

    localparam logic [1:0] FUNC_IMU   = 2'd0;
    localparam logic [1:0] FUNC_CMD   = 2'd1;
    localparam logic [1:0] FUNC_JOINT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_SPEED      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_PITCH_RATE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_YAW_RATE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_PITCH      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_SPEED_INT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_YAW_INT    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_LIMIT     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_INT_LIMIT       = 3'd7;

    localparam logic [CFG_W-1:0] CFG_RESET [CFG_COUNT] = '{
        31'd50633, 31'd4227, 31'd6200, 31'd63544,
        31'd110894, 31'd5059, 31'd294912, 31'd131072
    };

    // Leg damping 0.1 in Q0.32, wheel radius 0.0183 in Q0.32,
    // radius over half track in Q0.30.
    localparam logic [MUL_B_W-1:0] KD_Q32 = 32'd429496730;
    localparam logic [MUL_B_W-1:0] R_Q32  = 32'd78597902;
    localparam logic [MUL_B_W-1:0] RD_Q30 = 32'd248664583;

    localparam logic signed [DATA_W-1:0] PITCH_LIMIT = 32'sd19660;
    localparam logic [DATA_W-1:0]        DT_LIMIT    = 32'd6553;

    typedef struct packed {
        logic [1:0]               func;
        logic signed [DATA_W-1:0] pitch;
        logic signed [DATA_W-1:0] pitch_rate;
        logic signed [DATA_W-1:0] target_speed;
        logic signed [DATA_W-1:0] target_yaw_rate;
        logic signed [DATA_W-1:0] left_leg_pos;
        logic signed [DATA_W-1:0] left_leg_vel;
        logic signed [DATA_W-1:0] right_leg_pos;
        logic signed [DATA_W-1:0] right_leg_vel;
        logic signed [DATA_W-1:0] left_wheel_vel;
        logic signed [DATA_W-1:0] right_wheel_vel;
        logic [DATA_W-1:0]        sample_time;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] leg_torque_l;
        logic signed [DATA_W-1:0] leg_torque_r;
        logic signed [DATA_W-1:0] wheel_torque_l;
        logic signed [DATA_W-1:0] wheel_torque_r;
        logic                     braking;
    } t_out_item;

endpackage

`default_nettype wire

// File: hdl/lqr_balance_wheel_leg_controller.sv
// Top level of the wheel-leg balance controller: event handshake, settings,
// controller state and the sequencer around one shared multiplier.
// Depends on lqrbw_pkg and lqrbw_mul.
//
// Usage: events enter on the input channel (valid/ready). IMU and command
// events update the stored pitch, pitch rate and targets and give no
// result. A joint event gives one result of four efforts on the
// output channel (valid/ready). Settings are written through the plain
// write port and take effect for the next joint event.
// A joint event walks a fixed sequence of twelve products through the
// single 33 x 32 multiplier, and the next event is taken in the cycle
// after the output transfer. IMU and command events are taken whenever
// the block is idle. A stalled receiver holds the result in the output
// register and the block takes no new event until the transfer. Reset
// restores the default settings, clears the stored pitch, pitch rate,
// targets, IMU flag, integrators and last sample time, and returns the
// block to idle.
`default_nettype none

module lqr_balance_wheel_leg_controller (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_ready,
    input  wire lqrbw_pkg::t_in_item                   i_in_item,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_ready,
    output lqrbw_pkg::t_out_item                       o_out_item,
    input  wire logic                                  i_cfg_we,
    input  wire logic [lqrbw_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [lqrbw_pkg::CFG_W-1:0]           i_cfg_data
);
    import lqrbw_pkg::*;

    localparam int unsigned ACC_W  = 51;
    localparam int unsigned TERM_W = MUL_P_W - 16;
    localparam int unsigned INT_W  = 34;
    localparam int unsigned SAT_W  = 36;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL_DX, S_MUL_DPSI, S_MUL_LLEG, S_MUL_RLEG, S_MUL_SINT,
        S_MUL_YINT, S_MUL_GS, S_MUL_GSI, S_MUL_GYI, S_MUL_GPR, S_MUL_GP,
        S_MUL_GYR, S_ACC_GYR, S_SUM, S_OUT
    } t_state;

    function automatic logic signed [DATA_W-1:0] f_sat32(input logic signed [SAT_W-1:0] v);
        logic signed [SAT_W-1:0] hi;
        logic signed [SAT_W-1:0] lo;
        hi = SAT_W'(32'sh7FFF_FFFF);
        lo = SAT_W'(32'sh8000_0000);
        if (v > hi) begin
            return 32'sh7FFF_FFFF;
        end else if (v < lo) begin
            return 32'sh8000_0000;
        end
        return v[DATA_W-1:0];
    endfunction

    function automatic logic signed [DATA_W-1:0] f_clamp_wheel(
        input logic signed [ACC_W-1:0] v,
        input logic [CFG_W-1:0]        lim
    );
        logic signed [ACC_W-1:0] hi;
        hi = $signed(ACC_W'(lim));
        if (v > hi) begin
            return hi[DATA_W-1:0];
        end else if (v < -hi) begin
            return DATA_W'(-hi);
        end
        return v[DATA_W-1:0];
    endfunction

    t_state r_state;
    logic [CFG_W-1:0] r_cfg [CFG_COUNT];

    logic signed [DATA_W-1:0] r_pitch;
    logic signed [DATA_W-1:0] r_pitch_rate;
    logic signed [DATA_W-1:0] r_target_speed;
    logic signed [DATA_W-1:0] r_target_yaw_rate;
    logic                     r_imu_seen;
    logic signed [DATA_W-1:0] r_speed_int;
    logic signed [DATA_W-1:0] r_yaw_int;
    logic [DATA_W-1:0]        r_last_time;

    t_in_item                 r_item;
    logic                     r_brake;
    logic signed [DATA_W-1:0] r_es;
    logic signed [DATA_W-1:0] r_ey;
    logic signed [DATA_W-1:0] r_leg_l;
    logic signed [DATA_W-1:0] r_leg_r;
    logic signed [ACC_W-1:0]  r_common;
    logic signed [ACC_W-1:0]  r_diff;
    t_out_item                r_out_item;

    logic signed [MUL_A_W-1:0] w_a;
    logic signed [MUL_B_W-1:0] w_b;
    logic signed [MUL_P_W-1:0] w_prod;
    logic signed [MUL_P_W-1:0] w_neg_prod;
    logic signed [TERM_W-1:0]  w_term;
    logic signed [TERM_W-1:0]  w_neg_term;
    logic signed [ACC_W-1:0]   w_term_ext;
    logic signed [MUL_A_W-1:0] w_wheel_sum;
    logic signed [MUL_A_W-1:0] w_wheel_dif;
    logic [DATA_W-1:0]         w_dt;
    logic                      w_dt_ok;
    logic                      w_pitch_ok;
    logic signed [DATA_W-1:0]  w_dx;
    logic signed [INT_W-1:0]   w_dpsi;
    logic signed [DATA_W-1:0]  w_leg_pos;
    logic signed [SAT_W-1:0]   w_pos5;
    logic signed [INT_W-1:0]   w_int_old;
    logic signed [INT_W-1:0]   w_int_cand;
    logic signed [INT_W-1:0]   w_int_lim;
    logic signed [MUL_A_W-1:0] w_neg_lw;
    logic signed [MUL_A_W-1:0] w_neg_rw;
    logic signed [ACC_W-1:0]   w_lwe_acc;
    logic signed [ACC_W-1:0]   w_rwe_acc;

    logic signed [DATA_W-1:0]  n_es;
    logic signed [DATA_W-1:0]  n_ey;
    logic signed [DATA_W-1:0]  n_leg;
    logic signed [DATA_W-1:0]  n_int;

    lqrbw_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_a),
        .i_b   (w_b),
        .o_p   (w_prod)
    );

    assign w_wheel_sum = MUL_A_W'($signed(r_item.left_wheel_vel))
                       + MUL_A_W'($signed(r_item.right_wheel_vel));
    assign w_wheel_dif = MUL_A_W'($signed(r_item.right_wheel_vel))
                       - MUL_A_W'($signed(r_item.left_wheel_vel));
    assign w_dt        = r_item.sample_time - r_last_time;

    always_comb begin
        unique case (r_state)
            S_MUL_DX: begin
                w_a = w_wheel_sum;
                w_b = $signed(R_Q32);
            end
            S_MUL_DPSI: begin
                w_a = w_wheel_dif;
                w_b = $signed(RD_Q30);
            end
            S_MUL_LLEG: begin
                w_a = MUL_A_W'($signed(r_item.left_leg_vel));
                w_b = $signed(KD_Q32);
            end
            S_MUL_RLEG: begin
                w_a = MUL_A_W'($signed(r_item.right_leg_vel));
                w_b = $signed(KD_Q32);
            end
            S_MUL_SINT: begin
                w_a = MUL_A_W'(r_es);
                w_b = $signed({1'b0, w_dt[DATA_W-2:0]});
            end
            S_MUL_YINT: begin
                w_a = MUL_A_W'(r_ey);
                w_b = $signed({1'b0, w_dt[DATA_W-2:0]});
            end
            S_MUL_GS: begin
                w_a = MUL_A_W'(r_es);
                w_b = $signed({1'b0, r_cfg[CFG_GAIN_SPEED]});
            end
            S_MUL_GSI: begin
                w_a = MUL_A_W'(r_speed_int);
                w_b = $signed({1'b0, r_cfg[CFG_GAIN_SPEED_INT]});
            end
            S_MUL_GYI: begin
                w_a = MUL_A_W'(r_yaw_int);
                w_b = $signed({1'b0, r_cfg[CFG_GAIN_YAW_INT]});
            end
            S_MUL_GPR: begin
                w_a = MUL_A_W'(r_pitch_rate);
                w_b = $signed({1'b0, r_cfg[CFG_GAIN_PITCH_RATE]});
            end
            S_MUL_GP: begin
                w_a = MUL_A_W'(r_pitch);
                w_b = $signed({1'b0, r_cfg[CFG_GAIN_PITCH]});
            end
            S_MUL_GYR: begin
                w_a = MUL_A_W'(r_ey);
                w_b = $signed({1'b0, r_cfg[CFG_GAIN_YAW_RATE]});
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    assign w_neg_prod = -w_prod;
    assign w_term     = w_prod[MUL_P_W-1:16];
    assign w_neg_term = w_neg_prod[MUL_P_W-1:16];
    assign w_term_ext = ACC_W'(w_term);

    assign w_dx   = w_prod[MUL_P_W-1:33];
    assign w_dpsi = w_prod[63:30];
    assign n_es   = f_sat32(SAT_W'(w_dx) - SAT_W'(r_target_speed));
    assign n_ey   = f_sat32(SAT_W'(w_dpsi) - SAT_W'(r_target_yaw_rate));

    assign w_leg_pos = (r_state == S_MUL_RLEG) ? $signed(r_item.left_leg_pos)
                                                : $signed(r_item.right_leg_pos);
    assign w_pos5    = (SAT_W'(w_leg_pos) <<< 2) + SAT_W'(w_leg_pos);
    assign n_leg     = f_sat32(SAT_W'($signed(w_neg_prod[MUL_P_W-1:32])) - w_pos5);

    assign w_pitch_ok = (r_pitch >= -PITCH_LIMIT) && (r_pitch <= PITCH_LIMIT);
    assign w_dt_ok    = (w_dt != '0) && (w_dt <= DT_LIMIT);
    assign w_int_old  = (r_state == S_MUL_YINT) ? INT_W'(r_speed_int) : INT_W'(r_yaw_int);
    assign w_int_lim  = $signed(INT_W'(r_cfg[CFG_INT_LIMIT]));

    always_comb begin
        priority if (!w_pitch_ok) begin
            w_int_cand = '0;
        end else if (w_dt_ok) begin
            w_int_cand = w_int_old + INT_W'(w_neg_term);
        end else begin
            w_int_cand = w_int_old;
        end
        priority if (w_int_cand > w_int_lim) begin
            n_int = w_int_lim[DATA_W-1:0];
        end else if (w_int_cand < -w_int_lim) begin
            n_int = DATA_W'(-w_int_lim);
        end else begin
            n_int = w_int_cand[DATA_W-1:0];
        end
    end

    assign w_neg_lw  = -MUL_A_W'($signed(r_item.left_wheel_vel));
    assign w_neg_rw  = -MUL_A_W'($signed(r_item.right_wheel_vel));
    assign w_lwe_acc = r_common + r_diff;
    assign w_rwe_acc = r_common - r_diff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CFG_COUNT; i++) begin
                r_cfg[i] <= CFG_RESET[i];
            end
        end else if (i_cfg_we) begin
            r_cfg[i_cfg_index] <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state           <= S_IDLE;
            r_pitch           <= '0;
            r_pitch_rate      <= '0;
            r_target_speed    <= '0;
            r_target_yaw_rate <= '0;
            r_imu_seen        <= 1'b0;
            r_speed_int       <= '0;
            r_yaw_int         <= '0;
            r_last_time       <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        unique case (i_in_item.func)
                            FUNC_IMU: begin
                                r_pitch      <= i_in_item.pitch;
                                r_pitch_rate <= i_in_item.pitch_rate;
                                r_imu_seen   <= 1'b1;
                            end
                            FUNC_CMD: begin
                                r_target_speed    <= i_in_item.target_speed;
                                r_target_yaw_rate <= i_in_item.target_yaw_rate;
                            end
                            FUNC_JOINT: begin
                                r_item  <= i_in_item;
                                r_brake <= !r_imu_seen;
                                r_state <= S_MUL_DX;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_MUL_DX: begin
                    r_state <= S_MUL_DPSI;
                end
                S_MUL_DPSI: begin
                    r_es    <= n_es;
                    r_state <= S_MUL_LLEG;
                end
                S_MUL_LLEG: begin
                    r_ey    <= n_ey;
                    r_state <= S_MUL_RLEG;
                end
                S_MUL_RLEG: begin
                    r_leg_l <= n_leg;
                    r_state <= S_MUL_SINT;
                end
                S_MUL_SINT: begin
                    r_leg_r <= n_leg;
                    r_state <= S_MUL_YINT;
                end
                S_MUL_YINT: begin
                    if (!r_brake) begin
                        r_speed_int <= n_int;
                    end
                    r_state <= S_MUL_GS;
                end
                S_MUL_GS: begin
                    if (!r_brake) begin
                        r_yaw_int <= n_int;
                    end
                    r_state <= S_MUL_GSI;
                end
                S_MUL_GSI: begin
                    r_common <= w_term_ext;
                    r_state  <= S_MUL_GYI;
                end
                S_MUL_GYI: begin
                    r_common <= r_common - w_term_ext;
                    r_state  <= S_MUL_GPR;
                end
                S_MUL_GPR: begin
                    r_diff  <= -w_term_ext;
                    r_state <= S_MUL_GP;
                end
                S_MUL_GP: begin
                    r_common <= r_common + w_term_ext;
                    r_state  <= S_MUL_GYR;
                end
                S_MUL_GYR: begin
                    r_common <= r_common + w_term_ext;
                    r_state  <= S_ACC_GYR;
                end
                S_ACC_GYR: begin
                    r_diff  <= r_diff + w_term_ext;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_out_item.leg_torque_l <= r_leg_l;
                    r_out_item.leg_torque_r <= r_leg_r;
                    r_out_item.braking      <= r_brake;
                    if (r_brake) begin
                        r_out_item.wheel_torque_l <= w_neg_lw[MUL_A_W-1:1];
                        r_out_item.wheel_torque_r <= w_neg_rw[MUL_A_W-1:1];
                    end else begin
                        r_out_item.wheel_torque_l <=
                            f_clamp_wheel(w_lwe_acc, r_cfg[CFG_WHEEL_LIMIT]);
                        r_out_item.wheel_torque_r <=
                            f_clamp_wheel(w_rwe_acc, r_cfg[CFG_WHEEL_LIMIT]);
                        r_last_time <= r_item.sample_time;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_out_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_out_item  = r_out_item;

    a_ready_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("Input ready and output valid are high together.");

    a_imu_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$fell(r_imu_seen))
        else $error("IMU-seen flag cleared outside reset.");

    a_ready_after_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready) |=> o_in_ready)
        else $error("Block not ready after an output transfer.");

    a_wheel_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(o_out_valid) && !o_out_item.braking) |->
            (o_out_item.wheel_torque_l <=
                 $signed({1'b0, $past(r_cfg[CFG_WHEEL_LIMIT])}) &&
             o_out_item.wheel_torque_l >=
                 -$signed({1'b0, $past(r_cfg[CFG_WHEEL_LIMIT])}) &&
             o_out_item.wheel_torque_r <=
                 $signed({1'b0, $past(r_cfg[CFG_WHEEL_LIMIT])}) &&
             o_out_item.wheel_torque_r >=
                 -$signed({1'b0, $past(r_cfg[CFG_WHEEL_LIMIT])})))
        else $error("Wheel effort outside its limit in balance mode.");

endmodule

`default_nettype wire

// File: hdl/lqrbw_mul.sv
// Shared signed multiplier with a registered product.
// Depends on lqrbw_pkg for operand widths.
`default_nettype none

module lqrbw_mul (
    input  wire logic                                  i_clk,
    input  wire logic signed [lqrbw_pkg::MUL_A_W-1:0]  i_a,
    input  wire logic signed [lqrbw_pkg::MUL_B_W-1:0]  i_b,
    output logic signed [lqrbw_pkg::MUL_P_W-1:0]       o_p
);
    import lqrbw_pkg::*;

    logic signed [MUL_P_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= MUL_P_W'(i_a) * MUL_P_W'(i_b);
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

// File: test/lqr_balance_wheel_leg_controller_tb.sv
// Self-checking testbench for the wheel-leg balance controller: directed and random
// events through valid/ready channels, checked against an in-bench effort predictor.
// Depends on lqrbw_pkg and the lqr_balance_wheel_leg_controller RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lqrbw_pkg::*;

    localparam logic [1:0]        FUNC_UNUSED = 2'd3;
    localparam logic signed [31:0] S_MIN      = 32'sh8000_0000;
    localparam logic signed [31:0] S_MAX      = 32'sh7fff_ffff;
    localparam longint             I32_MIN    = -64'sd2147483648;
    localparam longint             I32_MAX    = 64'sd2147483647;
    localparam int                 STALL_LIMIT = 4000;
    localparam int                 HOLD_CYCLES = 300;

    logic                   i_clk;
    logic                   i_rst_n     = 1'b0;
    logic                   i_in_valid  = 1'b0;
    logic                   o_in_ready;
    t_in_item               i_in_item   = '0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    t_out_item              o_out_item;
    logic                   i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = CFG_GAIN_SPEED;
    logic [CFG_W-1:0]       i_cfg_data  = '0;

    lqr_balance_wheel_leg_controller i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    t_in_item    event_queue [$];
    t_out_item   effort_queue [$];
    int          mismatches     = 0;
    int          send_idle_pct  = 0;
    int          stall_pct      = 0;
    bit          pressure_phase = 1'b0;
    logic [31:0] gen_time       = '0;

    longint      setting [CFG_COUNT];
    longint      ctl_pitch        = 0;
    longint      ctl_pitch_rate   = 0;
    longint      ctl_target_speed = 0;
    longint      ctl_target_yaw   = 0;
    bit          ctl_imu_seen     = 1'b0;
    longint      speed_acc        = 0;
    longint      yaw_acc          = 0;
    logic [31:0] ctl_last_time    = '0;

    initial begin
        for (int i = 0; i < CFG_COUNT; i++) begin
            setting[i] = longint'(CFG_RESET[i]);
        end
    end

    function automatic longint sat(input longint v, input longint lo, input longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic longint gain_term(input longint g, input longint x);
        return (g * x) >>> 16;
    endfunction

    function automatic longint leg_pd(input longint pos, input longint vel);
        longint kd;
        kd = longint'(KD_Q32);
        return sat(-5 * pos + ((-vel * kd) >>> 32), I32_MIN, I32_MAX);
    endfunction

    function automatic bit apply_event(input t_in_item ev, output t_out_item eff);
        longint      lw, rw, lwe, rwe, dx, dpsi, es, ey, ap, lim, wl, common, dtl;
        logic [31:0] dt;
        eff = '0;
        case (ev.func)
            FUNC_IMU: begin
                ctl_pitch      = longint'($signed(ev.pitch));
                ctl_pitch_rate = longint'($signed(ev.pitch_rate));
                ctl_imu_seen   = 1'b1;
                return 1'b0;
            end
            FUNC_CMD: begin
                ctl_target_speed = longint'($signed(ev.target_speed));
                ctl_target_yaw   = longint'($signed(ev.target_yaw_rate));
                return 1'b0;
            end
            FUNC_JOINT: begin
                lw = longint'($signed(ev.left_wheel_vel));
                rw = longint'($signed(ev.right_wheel_vel));
                if (!ctl_imu_seen) begin
                    lwe = (-lw) >>> 1;
                    rwe = (-rw) >>> 1;
                    eff.braking = 1'b1;
                end else begin
                    dt   = ev.sample_time - ctl_last_time;
                    dtl  = longint'({32'd0, dt});
                    dx   = ((lw + rw) * longint'(R_Q32)) >>> 33;
                    dpsi = ((rw - lw) * longint'(RD_Q30)) >>> 30;
                    es   = sat(dx - ctl_target_speed, I32_MIN, I32_MAX);
                    ey   = sat(dpsi - ctl_target_yaw, I32_MIN, I32_MAX);
                    lim  = setting[CFG_INT_LIMIT];
                    wl   = setting[CFG_WHEEL_LIMIT];
                    ap   = (ctl_pitch < 0) ? -ctl_pitch : ctl_pitch;
                    if (ap <= longint'(PITCH_LIMIT)) begin
                        if (dt != 0 && dt <= DT_LIMIT) begin
                            speed_acc += (-es * dtl) >>> 16;
                            yaw_acc   += (-ey * dtl) >>> 16;
                        end
                    end else begin
                        speed_acc = 0;
                        yaw_acc   = 0;
                    end
                    ctl_last_time = ev.sample_time;
                    speed_acc = sat(speed_acc, -lim, lim);
                    yaw_acc   = sat(yaw_acc, -lim, lim);
                    common = gain_term(setting[CFG_GAIN_SPEED], es)
                           + gain_term(setting[CFG_GAIN_PITCH_RATE], ctl_pitch_rate)
                           + gain_term(setting[CFG_GAIN_PITCH], ctl_pitch)
                           - gain_term(setting[CFG_GAIN_SPEED_INT], speed_acc);
                    lwe = common + gain_term(setting[CFG_GAIN_YAW_RATE], ey)
                        - gain_term(setting[CFG_GAIN_YAW_INT], yaw_acc);
                    rwe = common - gain_term(setting[CFG_GAIN_YAW_RATE], ey)
                        + gain_term(setting[CFG_GAIN_YAW_INT], yaw_acc);
                    lwe = sat(lwe, -wl, wl);
                    rwe = sat(rwe, -wl, wl);
                    eff.braking = 1'b0;
                end
                eff.leg_torque_l   = leg_pd(longint'($signed(ev.left_leg_pos)),
                                            longint'($signed(ev.left_leg_vel)));
                eff.leg_torque_r   = leg_pd(longint'($signed(ev.right_leg_pos)),
                                            longint'($signed(ev.right_leg_vel)));
                eff.wheel_torque_l = lwe[31:0];
                eff.wheel_torque_r = rwe[31:0];
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic signed [31:0] rand_val();
        if ($urandom_range(3) == 0) return $urandom;
        return $signed($urandom) >>> $urandom_range(8, 26);
    endfunction

    function automatic t_in_item noise_event();
        logic [$bits(t_in_item)-1:0] raw;
        raw = '0;
        repeat (12) raw = {raw[$bits(t_in_item)-33:0], 32'($urandom)};
        return t_in_item'(raw);
    endfunction

    function automatic t_in_item imu_event(input logic signed [31:0] p, r);
        t_in_item ev;
        ev = noise_event();
        ev.func       = FUNC_IMU;
        ev.pitch      = p;
        ev.pitch_rate = r;
        return ev;
    endfunction

    function automatic t_in_item command_event(input logic signed [31:0] s, y);
        t_in_item ev;
        ev = noise_event();
        ev.func            = FUNC_CMD;
        ev.target_speed    = s;
        ev.target_yaw_rate = y;
        return ev;
    endfunction

    function automatic t_in_item joint_event(input logic signed [31:0] lw, rw,
                                             input logic [31:0] t);
        t_in_item ev;
        ev = noise_event();
        ev.func            = FUNC_JOINT;
        ev.left_leg_pos    = rand_val();
        ev.left_leg_vel    = rand_val();
        ev.right_leg_pos   = rand_val();
        ev.right_leg_vel   = rand_val();
        ev.left_wheel_vel  = lw;
        ev.right_wheel_vel = rw;
        ev.sample_time     = t;
        return ev;
    endfunction

    function automatic t_in_item random_event();
        t_in_item    ev;
        int unsigned pick;
        logic [31:0] p;
        pick = $urandom_range(99);
        if (pick < 22) begin
            p = ($urandom_range(9) < 7) ? $urandom_range(40000) - 20000 : rand_val();
            ev = imu_event(p, rand_val());
        end else if (pick < 32) begin
            ev = command_event(rand_val(), rand_val());
        end else if (pick < 95) begin
            gen_time += ($urandom_range(9) == 0) ? $urandom : $urandom_range(7000);
            ev = joint_event(rand_val(), rand_val(), gen_time);
        end else begin
            ev = noise_event();
            ev.func = FUNC_UNUSED;
        end
        return ev;
    endfunction

    t_out_item driver_eff;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                if (apply_event(i_in_item, driver_eff)) effort_queue.push_back(driver_eff);
            end
            if (!i_in_valid || o_in_ready) begin
                if (event_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_in_item  <= event_queue.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic compare_field(input string name, input logic signed [31:0] want, got);
        if (got !== want) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    t_out_item want_eff;
    int        hold_left = 0;
    bit        hold_done = 1'b0;

    always @(posedge i_clk) begin
        if (pressure_phase && !hold_done) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (effort_queue.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got %p", $time, o_out_item);
                    mismatches++;
                end else begin
                    want_eff = effort_queue.pop_front();
                    compare_field("leg_torque_l", want_eff.leg_torque_l,
                                  o_out_item.leg_torque_l);
                    compare_field("leg_torque_r", want_eff.leg_torque_r,
                                  o_out_item.leg_torque_r);
                    compare_field("wheel_torque_l", want_eff.wheel_torque_l,
                                  o_out_item.wheel_torque_l);
                    compare_field("wheel_torque_r", want_eff.wheel_torque_r,
                                  o_out_item.wheel_torque_r);
                    compare_field("braking", {31'd0, want_eff.braking},
                                  {31'd0, o_out_item.braking});
                end
            end
            if (hold_left > 0) begin
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL lqr_balance_wheel_leg_controller");
            $finish;
        end
    end

    task automatic wait_idle();
        do @(negedge i_clk);
        while (event_queue.size() != 0 || i_in_valid || effort_queue.size() != 0);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_setting(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        setting[idx] = longint'(val);
    endtask

    task automatic load_settings(input logic [CFG_W-1:0] gs, gpr, gyr, gp, gsi, gyi, wl, il);
        write_setting(CFG_GAIN_SPEED, gs);
        write_setting(CFG_GAIN_PITCH_RATE, gpr);
        write_setting(CFG_GAIN_YAW_RATE, gyr);
        write_setting(CFG_GAIN_PITCH, gp);
        write_setting(CFG_GAIN_SPEED_INT, gsi);
        write_setting(CFG_GAIN_YAW_INT, gyi);
        write_setting(CFG_WHEEL_LIMIT, wl);
        write_setting(CFG_INT_LIMIT, il);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_random(input int count, input int send_idle, input int stall,
                              input bit press);
        @(negedge i_clk);
        send_idle_pct  = send_idle;
        stall_pct      = stall;
        pressure_phase = press;
        repeat (count) event_queue.push_back(random_event());
        wait_idle();
    endtask

    initial begin
        t_in_item ev;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Brake mode comes first, since the IMU flag is only cleared by reset.
        ev = joint_event(S_MIN, S_MAX, 32'd0);
        ev.left_leg_pos  = S_MIN;
        ev.left_leg_vel  = S_MAX;
        ev.right_leg_pos = S_MAX;
        ev.right_leg_vel = S_MIN;
        event_queue.push_back(ev);
        ev = joint_event(S_MAX, S_MIN, 32'd0);
        ev.left_leg_pos  = S_MAX;
        ev.left_leg_vel  = S_MIN;
        ev.right_leg_pos = S_MIN;
        ev.right_leg_vel = S_MAX;
        event_queue.push_back(ev);
        event_queue.push_back(joint_event(-32'sd1, 32'sd1, 32'd0));
        ev = noise_event();
        ev.func = FUNC_UNUSED;
        event_queue.push_back(ev);
        event_queue.push_back(command_event(32'sh0001_0000, 32'sd0));
        event_queue.push_back(imu_event(32'sd19660, -32'sd1000));
        event_queue.push_back(joint_event(rand_val(), rand_val(), 32'd100));
        event_queue.push_back(joint_event(rand_val(), rand_val(), 32'd100));
        event_queue.push_back(joint_event(rand_val(), rand_val(), 32'd6653));
        event_queue.push_back(joint_event(rand_val(), rand_val(), 32'd13207));
        event_queue.push_back(imu_event(-32'sd19660, S_MAX));
        event_queue.push_back(joint_event(rand_val(), rand_val(), 32'd13208));
        event_queue.push_back(imu_event(32'sd19661, rand_val()));
        event_queue.push_back(joint_event(rand_val(), rand_val(), 32'd13258));
        event_queue.push_back(imu_event(S_MIN, S_MIN));
        event_queue.push_back(joint_event(rand_val(), rand_val(), 32'd13300));
        event_queue.push_back(imu_event(32'sd0, 32'sd0));
        event_queue.push_back(command_event(S_MIN, S_MAX));
        event_queue.push_back(joint_event(S_MAX, S_MAX, 32'd19300));
        event_queue.push_back(command_event(S_MAX, S_MIN));
        event_queue.push_back(joint_event(S_MIN, S_MIN, 32'd25000));
        event_queue.push_back(joint_event(rand_val(), rand_val(), 32'hffff_fff0));
        event_queue.push_back(joint_event(rand_val(), rand_val(), 32'h0000_0010));
        event_queue.push_back(command_event(32'sd0, 32'sd0));
        gen_time = 32'h0000_0010;
        wait_idle();

        load_settings($urandom_range(1 << 18), $urandom_range(1 << 18),
                      $urandom_range(1 << 18), $urandom_range(1 << 18),
                      $urandom_range(1 << 18), $urandom_range(1 << 18),
                      $urandom_range(1 << 16, 1 << 24), $urandom_range(1 << 14, 1 << 20));
        run_random(240, 0, 0, 1'b0);

        load_settings(S_MAX[30:0], S_MAX[30:0], S_MAX[30:0], S_MAX[30:0],
                      S_MAX[30:0], S_MAX[30:0], S_MAX[30:0], S_MAX[30:0]);
        run_random(150, 56, 0, 1'b0);

        load_settings('0, '0, '0, '0, '0, '0, '0, '0);
        run_random(150, 0, 56, 1'b0);

        load_settings(CFG_RESET[CFG_GAIN_SPEED], CFG_RESET[CFG_GAIN_PITCH_RATE],
                      CFG_RESET[CFG_GAIN_YAW_RATE], CFG_RESET[CFG_GAIN_PITCH],
                      CFG_RESET[CFG_GAIN_SPEED_INT], CFG_RESET[CFG_GAIN_YAW_INT],
                      CFG_RESET[CFG_WHEEL_LIMIT], CFG_RESET[CFG_INT_LIMIT]);
        run_random(240, 14, 14, 1'b0);

        load_settings($urandom, $urandom, $urandom_range(1 << 20), $urandom_range(1 << 20),
                      $urandom, $urandom_range(1 << 20), $urandom, $urandom);
        run_random(150, 0, 0, 1'b1);

        if (mismatches == 0 && effort_queue.size() == 0) begin
            $display("PASS lqr_balance_wheel_leg_controller");
        end else begin
            $display("FAIL lqr_balance_wheel_leg_controller");
        end
        $finish;
    end

endmodule
